// ===== design/greedy_word_wrap_hyphenate_defines.svh =====
// Assertion macros for the word wrap block.
`ifndef GREEDY_WORD_WRAP_HYPHENATE_DEFINES_SVH
`define GREEDY_WORD_WRAP_HYPHENATE_DEFINES_SVH
`ifndef SYNTH
// Property that must hold at every edge outside reset.
`define GWWH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gwwh assertion failed");
// Implication from a cause to an effect, both sampled at one edge.
`define GWWH_ASSERT_IMP(lbl, clk, rst_n, cause, effect) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("gwwh implication failed");
`else
`define GWWH_ASSERT(lbl, clk, rst_n, prop)
`define GWWH_ASSERT_IMP(lbl, clk, rst_n, cause, effect)
`endif
`endif

// ===== design/gwwh_pkg.sv =====
// Shared types and constants for the greedy word wrap block.
`timescale 1ns / 1ps
package gwwh_pkg;

    localparam logic [7:0] SPACE_BYTE   = 8'h20;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] HYPHEN_BYTE  = 8'h2D;
    localparam logic [7:0] WIDTH_MIN    = 8'd2;
    localparam logic [7:0] WIDTH_RESET  = 8'd80;
    localparam int         ROOM_W       = 9;

    typedef enum logic [1:0] {
        SEP_NONE    = 2'd0,
        SEP_SPACE   = 2'd1,
        SEP_NEWLINE = 2'd2
    } t_sep;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_SEP,
        ST_LET,
        ST_HYP
    } t_state;

    typedef enum logic [1:0] {
        SEG_NONE,
        SEG_FIT,
        SEG_HYPH
    } t_seg_kind;

    typedef struct packed {
        logic accept;
        logic decide;
        logic emit_sep;
        logic emit_let;
        logic emit_hyp;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic      flush_start;
        logic      pos_done;
        t_seg_kind seg_kind;
        logic      sep_none;
        logic      piece_end;
        logic      piece_fit;
        logic      out_free;
    } t_status;

endpackage

// ===== design/greedy_word_wrap_hyphenate.sv =====
// Top level of the greedy word wrapper with hyphenation.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one text byte per item plus an
//   end-of-text flag. Bytes other than space are buffered (up to WORD_MAX letters;
//   extra letters are dropped and flag every output item of that word).
//   A space or end of text closes the word; the word is then sent out on the
//   output channel (o_out_valid / i_out_ready), one character per item: pending
//   separator, letters, hyphens at split points. The last item of a word has
//   o_last_of_run set. Empty words give no items.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the line width; write it only
//   while the block is idle. Widths below two act as two.
// Sequence:
//   Letters are buffered as they are accepted. A closing byte is accepted and,
//   per segment of the word, the controller takes a decision, emits the
//   separator if one is pending, the letters and a hyphen at a split point,
//   then finishes the word. The controller works on one word at a time and
//   stops taking input while it emits.
// Reset (synchronous, active low): line width 80, empty word, fresh line,
// output empty. A stalled receiver holds the output register and the emission
// sequence waits; input is taken again once the word's last item is loaded.
module greedy_word_wrap_hyphenate
    import gwwh_pkg::*;
#(
    parameter int WORD_MAX = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_word_truncated
);

    t_cmd    cmd;
    t_status status;

    // sequencing: buffer, decide segment, separator, letters, hyphen
    gwwh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // storage, room arithmetic and output register
    gwwh_datapath #(
        .WORD_MAX (WORD_MAX)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_text_byte      (i_text_byte),
        .i_end_of_text    (i_end_of_text),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_last_of_run    (o_last_of_run),
        .o_word_truncated (o_word_truncated)
    );

endmodule

// ===== design/gwwh_ctrl.sv =====
// Controller state machine: sequences buffering and emission of one word.
`timescale 1ns / 1ps
module gwwh_ctrl
    import gwwh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.flush_start) begin
                        n_state = ST_SEG;
                    end
                end
            end
            ST_SEG: begin
                if (i_status.pos_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.decide = 1'b1;
                    unique case (i_status.seg_kind) inside
                        SEG_FIT, SEG_HYPH: begin
                            n_state = i_status.sep_none ? ST_LET : ST_SEP;
                        end
                        default: begin
                            n_state = ST_SEG;   // line break only, decide again
                        end
                    endcase
                end
            end
            ST_SEP: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sep = 1'b1;
                    n_state        = ST_LET;
                end
            end
            ST_LET: begin
                if (i_status.out_free) begin
                    o_cmd.emit_let = 1'b1;
                    if (i_status.piece_end) begin
                        n_state = i_status.piece_fit ? ST_SEG : ST_HYP;
                    end
                end
            end
            ST_HYP: begin
                if (i_status.out_free) begin
                    o_cmd.emit_hyp = 1'b1;
                    n_state        = ST_SEG;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/gwwh_datapath.sv =====
// Datapath: word buffer, line room tracking and output register.
`timescale 1ns / 1ps
`include "greedy_word_wrap_hyphenate_defines.svh"
module gwwh_datapath
    import gwwh_pkg::*;
#(
    parameter int WORD_MAX = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_word_truncated
);

    localparam int CNT_W = $clog2(WORD_MAX + 1);
    localparam int IDX_W = $clog2(WORD_MAX);

    logic [7:0]        r_store [WORD_MAX];
    logic [7:0]        r_line_width;
    logic [CNT_W-1:0]  r_len;
    logic [CNT_W-1:0]  r_pos;
    logic [CNT_W-1:0]  r_end;
    logic [ROOM_W-1:0] r_room;
    t_sep              r_sep;
    t_sep              r_sep_next;
    logic              r_ovf;
    logic              r_eot;
    logic              r_fit;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_trunc;

    logic [7:0]        width_eff;
    logic [ROOM_W-1:0] width9;
    logic              is_space;
    logic              closing;
    logic              flush_start;
    logic [CNT_W-1:0]  rest;
    logic [ROOM_W-1:0] rest9;
    logic [ROOM_W-1:0] piece_end9;
    logic              piece_end;
    logic              load;
    logic [7:0]        n_out_byte;
    t_seg_kind         seg_kind;

    assign width_eff   = (r_line_width < WIDTH_MIN) ? WIDTH_MIN : r_line_width;
    assign width9      = {1'b0, width_eff};
    assign is_space    = (i_text_byte == SPACE_BYTE);
    assign closing     = is_space | i_end_of_text;
    assign flush_start = closing & ((r_len != '0) | !is_space);
    assign rest        = r_len - r_pos;
    assign rest9       = ROOM_W'(rest);
    assign piece_end9  = ROOM_W'(r_pos) + r_room - ROOM_W'(1);
    assign piece_end   = ((r_pos + CNT_W'(1)) == r_end);
    assign load        = i_cmd.emit_sep | i_cmd.emit_let | i_cmd.emit_hyp;

    always_comb begin
        if (rest9 <= r_room) begin
            seg_kind = SEG_FIT;
        end else if ((rest9 > width9) && (r_room >= ROOM_W'(2))) begin
            seg_kind = SEG_HYPH;
        end else begin
            seg_kind = SEG_NONE;
        end
    end

    always_comb begin
        if (i_cmd.emit_sep) begin
            n_out_byte = (r_sep == SEP_SPACE) ? SPACE_BYTE : NEWLINE_BYTE;
        end else if (i_cmd.emit_hyp) begin
            n_out_byte = HYPHEN_BYTE;
        end else begin
            n_out_byte = r_store[r_pos[IDX_W-1:0]];
        end
    end

    assign o_status.flush_start = flush_start;
    assign o_status.pos_done    = (r_pos == r_len);
    assign o_status.seg_kind    = seg_kind;
    assign o_status.sep_none    = (r_sep == SEP_NONE);
    assign o_status.piece_end   = piece_end;
    assign o_status.piece_fit   = r_fit;
    assign o_status.out_free    = !r_out_valid | i_out_ready;

    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_last_of_run    = r_out_last;
    assign o_word_truncated = r_out_trunc;

    // word letters, output payload and segment decision state
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !is_space && (r_len < CNT_W'(WORD_MAX))) begin
            r_store[r_len[IDX_W-1:0]] <= i_text_byte;
        end
        if (load) begin
            r_out_byte  <= n_out_byte;
            r_out_last  <= i_cmd.emit_let & r_fit & piece_end;
            r_out_trunc <= r_ovf;
        end
        if (i_cmd.decide) begin
            r_fit <= (seg_kind == SEG_FIT);
            r_end <= (seg_kind == SEG_FIT) ? r_len : piece_end9[CNT_W-1:0];
            r_sep_next <= ((rest9 + ROOM_W'(1)) >= r_room) ? SEP_NEWLINE : SEP_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= WIDTH_RESET;
            r_len        <= '0;
            r_pos        <= '0;
            r_room       <= ROOM_W'(WIDTH_RESET);
            r_sep        <= SEP_NONE;
            r_ovf        <= 1'b0;
            r_eot        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_line_width <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                if (!is_space) begin
                    if (r_len < CNT_W'(WORD_MAX)) begin
                        r_len <= r_len + CNT_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                if (flush_start) begin
                    r_pos <= '0;
                    r_eot <= i_end_of_text;
                end else if (closing && i_end_of_text) begin
                    r_room <= width9;
                    r_sep  <= SEP_NONE;
                end
            end
            if (i_cmd.decide) begin
                unique case (seg_kind)
                    SEG_FIT: begin
                        if ((rest9 + ROOM_W'(1)) >= r_room) begin
                            r_room <= width9;
                        end else begin
                            r_room <= r_room - rest9 - ROOM_W'(1);
                        end
                    end
                    SEG_HYPH: begin
                        r_room <= width9;
                    end
                    default: begin
                        r_room <= width9;
                        r_sep  <= SEP_NEWLINE;
                    end
                endcase
            end
            if (i_cmd.emit_let) begin
                r_pos <= r_pos + CNT_W'(1);
                if (piece_end && r_fit) begin
                    r_sep <= r_sep_next;
                end
            end
            if (i_cmd.emit_hyp) begin
                r_sep <= SEP_NEWLINE;
            end
            if (i_cmd.finish) begin
                r_len <= '0;
                r_pos <= '0;
                r_ovf <= 1'b0;
                if (r_eot) begin
                    r_room <= width9;
                    r_sep  <= SEP_NONE;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // room on a line never runs out without a line break
    `GWWH_ASSERT(a_room_nonzero, i_clk, i_rst_n, r_room != '0)
    // emission never reads past the buffered word
    `GWWH_ASSERT(a_pos_in_word, i_clk, i_rst_n, r_pos <= r_len)
    // dropped bytes only once the buffer is full
    `GWWH_ASSERT_IMP(a_ovf_full, i_clk, i_rst_n, r_ovf, r_len == CNT_W'(WORD_MAX))
    // the closing character of a word is a letter, never a space
    `GWWH_ASSERT_IMP(a_last_letter, i_clk, i_rst_n, r_out_valid && r_out_last,
        r_out_byte != SPACE_BYTE)

endmodule

// ===== tb/greedy_word_wrap_hyphenate_test.sv =====
// Self-checking testbench for the greedy word wrapper with hyphenation.
`timescale 1ns / 1ps
module greedy_word_wrap_hyphenate_test;
    import gwwh_pkg::*;

    localparam int WORD_MAX      = 16;
    localparam int SETTLE_CYCLES = 32;    // covers a letter accept plus the finish step
    localparam int STUCK_LIMIT   = 2000;  // cycles with no item moving on any channel
    localparam int REPORT_MAX    = 50;    // cap on printed mismatch lines
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 35;

    // One character of the wrapped output, as the block should send it.
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       cut;
    } t_wrap_char;

    // Tracks the wrapper state and keeps the characters still due on the output.
    class line_wrap_checker;
        logic [7:0] letters [WORD_MAX];
        int         letter_count;
        int         room_left;
        t_sep       sep;
        bit         dropped;
        logic [7:0] line_width;
        t_wrap_char due_chars [$];
        int         mismatches;

        function new();
            line_width   = WIDTH_RESET;
            letter_count = 0;
            room_left    = full_width();
            sep          = SEP_NONE;
            dropped      = 1'b0;
            mismatches   = 0;
        endfunction

        function int full_width();
            return (line_width < WIDTH_MIN) ? int'(WIDTH_MIN) : int'(line_width);
        endfunction

        function void set_line_width(logic [7:0] w);
            line_width = w;
        endfunction

        function int outstanding();
            return due_chars.size();
        endfunction

        function void put_char(logic [7:0] c);
            due_chars.push_back('{ch: c, last: 1'b0, cut: dropped});
        endfunction

        function void put_sep();
            if (sep == SEP_SPACE) begin
                put_char(SPACE_BYTE);
            end else if (sep == SEP_NEWLINE) begin
                put_char(NEWLINE_BYTE);
            end
        endfunction

        // Greedy wrap of the buffered word into the due queue.
        function void wrap_word();
            int w;
            int len;
            int pos;
            int rest;
            int piece;
            int first;
            t_wrap_char tail;
            w     = full_width();
            len   = letter_count;
            pos   = 0;
            first = due_chars.size();
            while (pos < len) begin
                rest = len - pos;
                if (rest <= room_left) begin
                    // rest of the word fits on this line
                    put_sep();
                    while (pos < len) begin
                        put_char(letters[pos]);
                        pos++;
                    end
                    room_left -= rest + 1;
                    sep = SEP_SPACE;
                    if (room_left <= 0) begin
                        room_left = w;
                        sep       = SEP_NEWLINE;
                    end
                end else if (rest > w && room_left >= 2) begin
                    // overlong: fill the line, leave one place for the hyphen
                    piece = room_left - 1;
                    put_sep();
                    for (int k = 0; k < piece; k++) begin
                        put_char(letters[pos]);
                        pos++;
                    end
                    put_char(HYPHEN_BYTE);
                    room_left = w;
                    sep       = SEP_NEWLINE;
                end else begin
                    // fits a fresh line only: break first
                    room_left = w;
                    sep       = SEP_NEWLINE;
                end
            end
            if (due_chars.size() > first) begin
                tail      = due_chars.pop_back();
                tail.last = 1'b1;
                due_chars.push_back(tail);
            end
        endfunction

        // Called for every accepted input item.
        function void take_text_byte(logic [7:0] b, logic eot);
            if (b != SPACE_BYTE) begin
                if (letter_count < WORD_MAX) begin
                    letters[letter_count] = b;
                    letter_count++;
                end else begin
                    dropped = 1'b1;
                end
            end
            if (b == SPACE_BYTE || eot) begin
                if (letter_count > 0) begin
                    wrap_word();
                end
                letter_count = 0;
                dropped      = 1'b0;
            end
            if (eot) begin
                room_left = full_width();
                sep       = SEP_NONE;
            end
        endfunction

        // Called for every accepted output item.
        function void check_out_char(logic [7:0] c, logic last, logic cut);
            t_wrap_char want;
            if (due_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected output item, expected none, actual %02h", $time, c);
            end else begin
                want = due_chars.pop_front();
                if (c !== want.ch) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: out_byte expected %02h actual %02h", $time, want.ch, c);
                end
                if (last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
                end
                if (cut !== want.cut) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: word_truncated expected %b actual %b", $time, want.cut, cut);
                end
            end
        endfunction
    endclass

    // Every block input has a known value from time zero.
    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_in_valid       = 1'b0;
    logic [7:0] i_text_byte      = 8'h00;
    logic       i_end_of_text    = 1'b0;
    logic       i_cfg_valid      = 1'b0;
    logic [7:0] i_cfg_data       = 8'h00;
    logic       i_out_ready      = 1'b0;
    logic       o_in_ready;
    logic       o_cfg_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;
    logic       o_word_truncated;

    line_wrap_checker wrap_chk;

    int          burst_left   = 0;   // items left in the current sender burst
    int          gap_max      = 6;   // 0 turns sender idling off for a phase
    int          stuck_cycles = 0;
    logic [15:0] ready_pattern = '1;
    logic [3:0]  ready_phase   = '0;
    logic [7:0]  phase_widths [PHASES];

    greedy_word_wrap_hyphenate #(
        .WORD_MAX(WORD_MAX)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_text_byte     (i_text_byte),
        .i_end_of_text   (i_end_of_text),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .o_word_truncated(o_word_truncated)
    );

    always #2 i_clk = ~i_clk;

    // Receiver: a fresh 16-bit ready pattern each round; about a third of
    // the rounds never stall, the rest stall on random bits.
    always @(posedge i_clk) begin
        if (ready_phase == 4'd0) begin
            ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        end
        i_out_ready <= ready_pattern[ready_phase];
        ready_phase <= ready_phase + 4'd1;
    end

    // Monitor: values read here are the ones seen by the edge, since all
    // drivers update through nonblocking assignments. Output is checked
    // before the input of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                wrap_chk.check_out_char(o_out_byte, o_last_of_run, o_word_truncated);
            end
            if (i_in_valid && o_in_ready) begin
                wrap_chk.take_text_byte(i_text_byte, i_end_of_text);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                wrap_chk.set_line_width(i_cfg_data);
            end
            // watchdog: nothing moving on any channel for too long
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Verification failed");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // Any byte but space; half of them lower-case letters for readable runs.
    function automatic logic [7:0] rand_letter();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 1) begin
            b = 8'($urandom_range(8'h61, 8'h7A));
        end else begin
            b = 8'($urandom_range(0, 255));
            if (b == SPACE_BYTE) b = 8'h5F;
        end
        return b;
    endfunction

    // Sends one input item. Bursts of random length with random gaps in
    // between; valid stays high inside a burst.
    task automatic send_text_byte(input logic [7:0] b, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
    endtask

    task automatic send_word(input int len, input bit eot_on_last);
        for (int i = 0; i < len; i++) begin
            send_text_byte(rand_letter(), eot_on_last && (i == len - 1));
        end
    endtask

    // Line width write; only issued while the block is idle.
    task automatic write_line_width(input logic [7:0] w);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, let every due character come out, then allow the
    // block to finish any item that gives no output.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (wrap_chk.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly well-formed words with random letters and closings; some noise
    // with stray spaces and end-of-text flags anywhere.
    task automatic run_text(input int budget);
        int sent;
        int len;
        int pick;
        int closing;
        int n;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    send_text_byte(($urandom_range(0, 2) == 0) ? SPACE_BYTE : rand_letter(),
                                   1'($urandom_range(0, 7) == 0));
                end
                sent += n;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 7) len = $urandom_range(1, 8);
                else if (pick < 9) len = $urandom_range(9, WORD_MAX);
                else len = $urandom_range(WORD_MAX + 1, WORD_MAX + 6);   // overflows buffer
                closing = $urandom_range(0, 9);
                send_word(len, closing == 0);      // end of text on the last letter
                sent += len;
                if (closing == 1) begin
                    send_text_byte(SPACE_BYTE, 1'b1);
                    sent += 1;
                end else if (closing == 2) begin
                    // end of text with nothing buffered
                    send_text_byte(SPACE_BYTE, 1'b0);
                    send_text_byte(SPACE_BYTE, 1'b1);
                    sent += 2;
                end else if (closing != 0) begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_text_byte(SPACE_BYTE, 1'b0);
                    sent += n;
                end
            end
        end
        // close the phase; without end of text the next width lands mid-text
        send_text_byte(SPACE_BYTE, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        wrap_chk = new();
        phase_widths[0] = 8'd2;
        phase_widths[1] = 8'd255;
        phase_widths[2] = 8'd3;
        phase_widths[3] = 8'd1;                     // below the minimum, acts as two
        phase_widths[4] = 8'($urandom_range(4, 10));
        phase_widths[5] = 8'($urandom_range(11, 40));
        phase_widths[6] = 8'd2;
        phase_widths[7] = 8'($urandom_range(2, 255));
        phase_widths[8] = 8'd6;
        phase_widths[9] = 8'($urandom_range(2, 20));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, at the reset width: extreme letters incl. NUL and newline,
        // a run of spaces, end of text on a letter, end of text with an empty
        // word, then a word that overflows the buffer and ends the text.
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(NEWLINE_BYTE, 1'b0);
        send_text_byte(SPACE_BYTE, 1'b0);
        send_text_byte(SPACE_BYTE, 1'b0);
        send_text_byte(SPACE_BYTE, 1'b0);
        send_text_byte(8'h41, 1'b1);
        send_text_byte(SPACE_BYTE, 1'b1);
        for (int i = 0; i <= WORD_MAX; i++) begin
            send_text_byte(8'h61 + 8'(i), i == WORD_MAX);
        end
        wait_idle();

        // Random phases, each at its own width; every third one without
        // sender gaps.
        for (int p = 0; p < PHASES; p++) begin
            write_line_width(phase_widths[p]);
            gap_max = (p % 3 == 2) ? 0 : 6;
            run_text(PHASE_ITEMS);
            wait_idle();
        end

        if (wrap_chk.mismatches == 0 && wrap_chk.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
